FILE: rtl/core/i2c_bitbang_master_assert.svh
// Assertion macros for the checker of the I2C bit-bang master.
// No dependencies; include by bare file name inside a module body.
`ifndef I2C_BITBANG_MASTER_ASSERT_SVH
`define I2C_BITBANG_MASTER_ASSERT_SVH

// Check a property outside of reset.
`define I2CBB_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check a property at every edge, reset included.
`define I2CBB_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: rtl/core/i2cbb_pkg.sv
// Shared types and constants of the I2C bit-bang master.
// No dependencies; imported by the front end, queue, sequencer and top level.
package i2cbb_pkg;

  typedef enum logic [2:0] {
    KIND_START_WR = 3'd0,
    KIND_WR_BYTE  = 3'd1,
    KIND_START_RD = 3'd2,
    KIND_RD_BYTE  = 3'd3,
    KIND_STOP     = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_WRITE,
    PH_READ
  } phase_e;

  typedef enum logic [1:0] {
    SEG_START,
    SEG_TX,
    SEG_RX,
    SEG_STOP
  } seg_e;

  typedef struct packed {
    logic       has_start;
    logic       has_tx;
    logic       has_rx;
    logic       has_stop;
    logic [7:0] data;
    logic       ack_this;
    logic       seen;
    logic [7:0] ack_count;
    logic       aborted;
  } cmd_t;

  typedef struct packed {
    logic       scl;
    logic       sda_release;
    logic       sample_point;
    logic       last;
    logic       ack_seen;
    logic [7:0] read_byte;
    logic [7:0] ack_count;
    logic       aborted;
  } event_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [3:0] ACK_SLOT     = 4'd8;
  localparam logic [3:0] LAST_DATA    = 4'd7;
  localparam logic [7:0] ACK_SAT      = 8'hFF;

endpackage

FILE: rtl/core/i2cbb_front.sv
// Command front end: address register, transaction state, command decode.
// Depends on i2cbb_pkg; pushes one pin-sequence descriptor per live command.
module i2cbb_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [6:0]          cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [2:0]          kind_i,
  input  logic [7:0]          data_byte_i,
  input  logic                ack_sample_i,
  input  logic [7:0]          sda_bits_i,
  input  logic                ack_this_i,
  input  logic                continue_count_i,
  input  i2cbb_pkg::q_status_t q_status_i,
  output logic                push_o,
  output i2cbb_pkg::cmd_t     cmd_o
);
  import i2cbb_pkg::*;

  logic [6:0] addr_q;
  phase_e     phase_q, phase_d;
  logic [7:0] cnt_q, cnt_d;
  logic       abort_q, abort_d;
  logic       accept;
  logic       live;
  logic       seen;
  logic [7:0] cnt_base;

  assign in_ready_o = !q_status_i.full;
  assign accept     = in_valid_i && !q_status_i.full;
  assign seen       = !ack_sample_i;

  always_comb begin
    phase_d  = phase_q;
    cnt_d    = cnt_q;
    abort_d  = abort_q;
    live     = 1'b0;
    cnt_base = cnt_q;
    cmd_o    = '0;
    unique case (kind_e'(kind_i))
      KIND_START_WR: begin
        live            = 1'b1;
        cmd_o.has_start = 1'b1;
        cmd_o.has_tx    = 1'b1;
        cmd_o.data      = {addr_q, 1'b0};
        cmd_o.has_stop  = !seen;
        cmd_o.seen      = seen;
        cnt_d           = seen ? 8'd1 : 8'd0;
        abort_d         = !seen;
        phase_d         = seen ? PH_WRITE : PH_IDLE;
      end
      KIND_WR_BYTE: begin
        if (phase_q == PH_WRITE) begin
          live           = 1'b1;
          cmd_o.has_tx   = 1'b1;
          cmd_o.data     = data_byte_i;
          cmd_o.has_stop = !seen;
          cmd_o.seen     = seen;
          if (seen) begin
            cnt_d = (cnt_q == ACK_SAT) ? cnt_q : cnt_q + 8'd1;
          end else begin
            abort_d = 1'b1;
            phase_d = PH_IDLE;
          end
        end
      end
      KIND_START_RD: begin
        if (!(continue_count_i && abort_q)) begin
          live            = 1'b1;
          cnt_base        = continue_count_i ? cnt_q : 8'd0;
          cmd_o.has_start = 1'b1;
          cmd_o.has_tx    = 1'b1;
          cmd_o.data      = {addr_q, 1'b1};
          cmd_o.has_stop  = !seen;
          cmd_o.seen      = seen;
          abort_d         = !seen;
          phase_d         = seen ? PH_READ : PH_IDLE;
          cnt_d           = cnt_base;
          if (seen && cnt_base != ACK_SAT) begin
            cnt_d = cnt_base + 8'd1;
          end
        end
      end
      KIND_RD_BYTE: begin
        if (phase_q == PH_READ) begin
          live           = 1'b1;
          cmd_o.has_rx   = 1'b1;
          cmd_o.data     = sda_bits_i;
          cmd_o.ack_this = ack_this_i;
        end
      end
      KIND_STOP: begin
        if (phase_q != PH_IDLE) begin
          live           = 1'b1;
          cmd_o.has_stop = 1'b1;
          phase_d        = PH_IDLE;
        end
      end
      default: begin
        live = 1'b0;
      end
    endcase
    cmd_o.ack_count = cnt_d;
    cmd_o.aborted   = abort_d;
  end

  assign push_o = accept && live;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q  <= '0;
      phase_q <= PH_IDLE;
      cnt_q   <= '0;
      abort_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        addr_q <= cfg_wdata_i;
      end
      if (accept) begin
        phase_q <= phase_d;
        cnt_q   <= cnt_d;
        abort_q <= abort_d;
      end
    end
  end

endmodule

FILE: rtl/core/i2cbb_fifo.sv
// Short descriptor queue between the command front end and the pin sequencer.
// Depends on i2cbb_pkg for the descriptor type and the depth.
module i2cbb_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  i2cbb_pkg::cmd_t      push_data_i,
  input  logic                 pop_i,
  output i2cbb_pkg::cmd_t      pop_data_o,
  output i2cbb_pkg::q_status_t status_o
);
  import i2cbb_pkg::*;

  cmd_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q;
  logic [QPTR_W-1:0] rd_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              do_push;
  logic              do_pop;

  assign status_o.full  = (cnt_q == QCNT_W'(QDEPTH));
  assign status_o.empty = (cnt_q == '0);
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign pop_data_o     = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_q + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_q + QPTR_W'(1);
      end
      cnt_q <= cnt_q + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end
  end

endmodule

FILE: rtl/core/i2cbb_back.sv
// Pin sequencer: expands one descriptor into start, byte, ack and stop events.
// Depends on i2cbb_pkg; drives the registered output event.
module i2cbb_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  i2cbb_pkg::q_status_t q_status_i,
  input  i2cbb_pkg::cmd_t      cmd_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output i2cbb_pkg::event_t    out_event_o
);
  import i2cbb_pkg::*;

  logic       active_q, active_d;
  seg_e       seg_q, seg_d;
  logic [3:0] bit_q, bit_d;
  logic [1:0] sub_q, sub_d;
  logic [7:0] sh_q, sh_d;
  cmd_t       cmd_q;
  logic       scl_q, scl_d;
  logic       sda_q, sda_d;
  logic       valid_q;
  event_t     ev_q, ev_d;
  logic       issue;
  logic       seg_end;
  logic       smp;
  logic       last;

  assign issue = active_q && (!valid_q || out_ready_i);
  assign pop_o = !active_q && !q_status_i.empty;

  always_comb begin
    scl_d    = scl_q;
    sda_d    = sda_q;
    smp      = 1'b0;
    seg_end  = 1'b0;
    seg_d    = seg_q;
    bit_d    = bit_q;
    sub_d    = sub_q + 2'd1;
    sh_d     = sh_q;
    active_d = active_q;
    unique case (seg_q)
      SEG_START: begin
        unique case (sub_q)
          2'd0:    scl_d = 1'b1;
          2'd1:    sda_d = 1'b1;
          2'd2:    sda_d = 1'b0;
          default: begin
            scl_d   = 1'b0;
            seg_end = 1'b1;
            seg_d   = SEG_TX;
            bit_d   = '0;
            sub_d   = '0;
            sh_d    = cmd_q.data;
          end
        endcase
      end
      SEG_TX: begin
        if (sub_q == 2'd0) begin
          sda_d = (bit_q == ACK_SLOT) ? 1'b1 : sh_q[7];
        end else if (sub_q == 2'd1) begin
          scl_d = 1'b1;
          smp   = (bit_q == ACK_SLOT);
        end else begin
          scl_d = 1'b0;
          bit_d = bit_q + 4'd1;
          sub_d = '0;
          sh_d  = {sh_q[6:0], 1'b0};
          if (bit_q == ACK_SLOT) begin
            seg_end = 1'b1;
            seg_d   = SEG_STOP;
          end
        end
      end
      SEG_RX: begin
        if (sub_q == 2'd0) begin
          sda_d = (bit_q == ACK_SLOT) ? !cmd_q.ack_this : 1'b1;
        end else if (sub_q == 2'd1) begin
          scl_d = 1'b1;
          smp   = (bit_q != ACK_SLOT);
        end else begin
          scl_d = 1'b0;
          bit_d = bit_q + 4'd1;
          sub_d = (bit_q == LAST_DATA) ? 2'd0 : 2'd1;
          if (bit_q == ACK_SLOT) begin
            seg_end = 1'b1;
          end
        end
      end
      default: begin
        if (sub_q == 2'd0) begin
          sda_d = 1'b0;
        end else if (sub_q == 2'd1) begin
          scl_d = 1'b1;
        end else begin
          sda_d   = 1'b1;
          seg_end = 1'b1;
        end
      end
    endcase

    last = seg_end && (seg_q != SEG_START) && !(seg_q == SEG_TX && cmd_q.has_stop);
    if (seg_end && last) begin
      active_d = 1'b0;
    end
    if (pop_o) begin
      active_d = 1'b1;
      bit_d    = '0;
      sub_d    = '0;
      sh_d     = cmd_i.data;
      if (cmd_i.has_start) begin
        seg_d = SEG_START;
      end else if (cmd_i.has_tx) begin
        seg_d = SEG_TX;
      end else if (cmd_i.has_rx) begin
        seg_d = SEG_RX;
      end else begin
        seg_d = SEG_STOP;
      end
    end

    ev_d.scl          = scl_d;
    ev_d.sda_release  = sda_d;
    ev_d.sample_point = smp;
    ev_d.last         = last;
    ev_d.ack_seen     = last && cmd_q.seen;
    ev_d.read_byte    = (last && cmd_q.has_rx) ? cmd_q.data : 8'd0;
    ev_d.ack_count    = cmd_q.ack_count;
    ev_d.aborted      = cmd_q.aborted;
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cmd_q <= cmd_i;
    end
    if (issue) begin
      ev_q <= ev_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      seg_q    <= SEG_START;
      bit_q    <= '0;
      sub_q    <= '0;
      sh_q     <= '0;
      scl_q    <= 1'b1;
      sda_q    <= 1'b1;
      valid_q  <= 1'b0;
    end else begin
      if (issue || pop_o) begin
        active_q <= active_d;
        seg_q    <= seg_d;
        bit_q    <= bit_d;
        sub_q    <= sub_d;
        sh_q     <= sh_d;
      end
      if (issue) begin
        scl_q   <= scl_d;
        sda_q   <= sda_d;
        valid_q <= 1'b1;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = valid_q;
  assign out_event_o = ev_q;

endmodule

FILE: rtl/core/i2c_bitbang_master.sv
// Top level of the I2C bit-bang master: front end, descriptor queue, sequencer.
// Depends on i2cbb_pkg, i2cbb_front, i2cbb_fifo and i2cbb_back.
//
//   channel  | direction | handshake                | payload
//   ---------+-----------+--------------------------+-------------------------------
//   cfg      | in        | cfg_we_i                 | cfg_wdata_i = slave_address
//   s_axis   | in        | s_axis_tvalid/tready     | tuser = kind, tdata = fields
//   m_axis   | out       | m_axis_tvalid/tready     | tlast = last, tdata = fields
//
// One command makes 0 to 34 pin events, one event per cycle while m_axis_tready
// is high; the sequencer loads the next command from the queue once the current one ends.
// The two-entry queue lets the next commands be accepted while events still flow.
// Reset leaves SCL and SDA released, the phase idle, count and abort flag clear.
// Commands that cause no events are accepted and dropped without queue entries.
module i2c_bitbang_master (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [6:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // kind[2:0]
  input  logic [2:0]  s_axis_tuser,
  // data_byte[7:0], ack_sample[8], sda_bits[16:9], ack_this[17],
  // continue_count[18], zero[23:19]
  input  logic [23:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // scl[0], sda_release[1], sample_point[2], ack_seen[3], read_byte[11:4],
  // ack_count[19:12], aborted[20], zero[23:21]
  output logic [23:0] m_axis_tdata,
  output logic        m_axis_tlast
);
  import i2cbb_pkg::*;

  q_status_t q_status;
  cmd_t      push_cmd;
  cmd_t      pop_cmd;
  logic      push;
  logic      pop;
  event_t    ev;

  i2cbb_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (s_axis_tvalid),
    .in_ready_o       (s_axis_tready),
    .kind_i           (s_axis_tuser),
    .data_byte_i      (s_axis_tdata[7:0]),
    .ack_sample_i     (s_axis_tdata[8]),
    .sda_bits_i       (s_axis_tdata[16:9]),
    .ack_this_i       (s_axis_tdata[17]),
    .continue_count_i (s_axis_tdata[18]),
    .q_status_i       (q_status),
    .push_o           (push),
    .cmd_o            (push_cmd)
  );

  i2cbb_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .pop_i       (pop),
    .pop_data_o  (pop_cmd),
    .status_o    (q_status)
  );

  i2cbb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_status_i  (q_status),
    .cmd_i       (pop_cmd),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_event_o (ev)
  );

  assign m_axis_tlast = ev.last;
  assign m_axis_tdata = {3'b000, ev.aborted, ev.ack_count, ev.read_byte, ev.ack_seen,
                         ev.sample_point, ev.sda_release, ev.scl};

endmodule

FILE: rtl/core/i2cbb_checker.sv
// Port-level checks of the I2C bit-bang master, bound to the top level.
// Depends on i2c_bitbang_master_assert.svh for the assertion macros.
module i2cbb_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic        m_axis_tlast
);
`include "i2c_bitbang_master_assert.svh"

  `I2CBB_ASSERT_ALWAYS(a_no_out_in_reset, !rst_ni |-> !m_axis_tvalid, "output valid in reset")
  `I2CBB_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled transfer changed")
  `I2CBB_ASSERT(a_sample_scl_high, m_axis_tvalid && m_axis_tdata[2] |-> m_axis_tdata[0], "sample with SCL low")
  `I2CBB_ASSERT(a_result_on_last, m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[11:3] == 9'd0, "ack or byte before last event")

endmodule

bind i2c_bitbang_master i2cbb_checker u_i2cbb_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
